// ===== hw/rtl/buzzer_beep_pattern_sequencer_macros.svh =====
// Assertion macros shared by the buzzer sequencer RTL.
`ifndef BUZZER_BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define BUZZER_BEEP_PATTERN_SEQUENCER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BBPS_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define BBPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bbps_pkg.sv =====
package bbps_pkg;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_START_TEST  = 2'd1,
    OP_START_ALARM = 2'd2,
    OP_STOP        = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_TEST  = 3'b010,
    MODE_ALARM = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    START_NONE        = 2'd0,
    START_OK          = 2'd1,
    START_BUSY        = 2'd2,
    START_UNAVAILABLE = 2'd3
  } start_status_t;

  typedef enum logic [1:0] {
    FINISH_NONE      = 2'd0,
    FINISH_TEST_DONE = 2'd1,
    FINISH_STOPPED   = 2'd2,
    FINISH_ERROR     = 2'd3
  } finish_event_t;

  typedef enum logic [2:0] {
    REG_DEVICE_PRESENT  = 3'd0,
    REG_TEST_ON_MS      = 3'd1,
    REG_TEST_OFF_MS     = 3'd2,
    REG_ALARM_ON_MS     = 3'd3,
    REG_ALARM_OFF_MS    = 3'd4,
    REG_GROUP_PAUSE_MS  = 3'd5,
    REG_ALARM_LIMIT_MS  = 3'd6,
    REG_BEEPS_PER_GROUP = 3'd7
  } reg_index_t;

  localparam int unsigned RETRY_MS = 50;

  localparam logic [15:0] TEST_ON_RESET     = 16'd200;
  localparam logic [15:0] TEST_OFF_RESET    = 16'd200;
  localparam logic [15:0] ALARM_ON_RESET    = 16'd250;
  localparam logic [15:0] ALARM_OFF_RESET   = 16'd250;
  localparam logic [15:0] GROUP_PAUSE_RESET = 16'd1500;
  localparam logic [31:0] ALARM_LIMIT_RESET = 32'd60000;
  localparam logic [7:0]  BEEPS_RESET       = 8'd3;

endpackage

// ===== hw/rtl/buzzer_beep_pattern_sequencer.sv =====
// Buzzer pattern sequencer. Each request on the s_ side is either a one
// millisecond tick or a command (start test, start alarm, stop alarm), and
// each one produces exactly one result on the m_ side, carrying the buzzer
// level, the mode flags, the answer to a start and the finish event. A request
// is taken every clock cycle: the whole update is a single pass of adds and
// compares between the request and the result register, and a skid register
// behind the result register lets one more request in while a result is
// stalled, so the input only stalls when both hold unread results.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no request is in flight: the block does not enforce it.
`include "buzzer_beep_pattern_sequencer_macros.svh"

module buzzer_beep_pattern_sequencer
  import bbps_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] drive_ok, [7:1] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] buzzer_on, [1] pattern_active, [2] alarm_active,
                                 // [4:3] start_status, [6:5] finish_event, [7] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef logic [TIME_BITS-1:0] time_t;

  // Configuration registers
  logic        device_present;
  logic [15:0] test_on_ms;
  logic [15:0] test_off_ms;
  logic [15:0] alarm_on_ms;
  logic [15:0] alarm_off_ms;
  logic [15:0] group_pause_ms;
  logic [31:0] alarm_limit_ms;
  logic [7:0]  beeps_per_group;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_present  <= 1'b0;
      test_on_ms      <= TEST_ON_RESET;
      test_off_ms     <= TEST_OFF_RESET;
      alarm_on_ms     <= ALARM_ON_RESET;
      alarm_off_ms    <= ALARM_OFF_RESET;
      group_pause_ms  <= GROUP_PAUSE_RESET;
      alarm_limit_ms  <= ALARM_LIMIT_RESET;
      beeps_per_group <= BEEPS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DEVICE_PRESENT:  device_present  <= cfg_data[0];
        REG_TEST_ON_MS:      test_on_ms      <= cfg_data[15:0];
        REG_TEST_OFF_MS:     test_off_ms     <= cfg_data[15:0];
        REG_ALARM_ON_MS:     alarm_on_ms     <= cfg_data[15:0];
        REG_ALARM_OFF_MS:    alarm_off_ms    <= cfg_data[15:0];
        REG_GROUP_PAUSE_MS:  group_pause_ms  <= cfg_data[15:0];
        REG_ALARM_LIMIT_MS:  alarm_limit_ms  <= cfg_data;
        REG_BEEPS_PER_GROUP: beeps_per_group <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pattern state
  mode_t       mode, mode_next;
  logic        level, level_next;
  logic        stop_pending, stop_pending_next;
  logic [7:0]  beeps_begun, beeps_begun_next;
  time_t       time_now, time_now_next;
  time_t       next_edge, next_edge_next;
  time_t       alarm_begin, alarm_begin_next;

  start_status_t status;
  finish_event_t finish;

  logic    accept;
  opcode_t op;
  logic    drive_ok;

  time_t   tick_time;
  time_t   elapsed;
  time_t   edge_at;
  time_t   edge_diff;
  logic    is_alarm;
  logic    limit_hit;
  logic    stopping;
  logic    due;

  assign accept   = s_tvalid && s_tready;
  assign op       = opcode_t'(s_tuser);
  assign drive_ok = s_tdata[0];

  assign tick_time = time_now + time_t'(1);
  assign is_alarm  = (mode == MODE_ALARM);
  assign elapsed   = tick_time - alarm_begin;
  assign limit_hit = is_alarm && (CMP_BITS'(elapsed) >= CMP_BITS'(alarm_limit_ms));
  assign stopping  = stop_pending || limit_hit;
  assign edge_at   = limit_hit ? tick_time : next_edge;
  assign edge_diff = tick_time - edge_at;
  // The edge counts as reached while the wrapped distance to it is not negative.
  assign due       = !edge_diff[TIME_BITS-1];

  always_comb begin
    mode_next         = mode;
    level_next        = level;
    stop_pending_next = stop_pending;
    beeps_begun_next  = beeps_begun;
    time_now_next     = time_now;
    next_edge_next    = next_edge;
    alarm_begin_next  = alarm_begin;
    status            = START_NONE;
    finish            = FINISH_NONE;

    case (op)
      OP_TICK: begin
        time_now_next = tick_time;
        if (mode != MODE_IDLE) begin
          stop_pending_next = stopping;
          next_edge_next    = edge_at;
          if (stopping) begin
            if (due) begin
              if (!drive_ok) begin
                next_edge_next = tick_time + time_t'(RETRY_MS);
              end else begin
                finish = FINISH_STOPPED;
              end
            end
          end else if (due) begin
            if (level) begin
              if (!drive_ok) begin
                next_edge_next = tick_time + time_t'(RETRY_MS);
              end else begin
                level_next = 1'b0;
                if (beeps_begun >= beeps_per_group) begin
                  if (!is_alarm) begin
                    finish = FINISH_TEST_DONE;
                  end else begin
                    beeps_begun_next = '0;
                    next_edge_next   = tick_time + time_t'(group_pause_ms);
                  end
                end else begin
                  next_edge_next = tick_time +
                                   time_t'(is_alarm ? alarm_off_ms : test_off_ms);
                end
              end
            end else if (!drive_ok) begin
              finish = FINISH_ERROR;
            end else begin
              level_next       = 1'b1;
              beeps_begun_next = beeps_begun + 8'd1;
              next_edge_next   = tick_time + time_t'(is_alarm ? alarm_on_ms : test_on_ms);
            end
          end
          // Any finish event returns the sequencer to idle with the buzzer off.
          if (finish != FINISH_NONE) begin
            mode_next         = MODE_IDLE;
            level_next        = 1'b0;
            stop_pending_next = 1'b0;
            beeps_begun_next  = '0;
            next_edge_next    = '0;
            alarm_begin_next  = '0;
          end
        end
      end
      OP_START_TEST, OP_START_ALARM: begin
        if (!device_present) begin
          status = START_UNAVAILABLE;
        end else if (mode != MODE_IDLE) begin
          status = START_BUSY;
        end else if (!drive_ok) begin
          status = START_UNAVAILABLE;
        end else begin
          status            = START_OK;
          mode_next         = (op == OP_START_ALARM) ? MODE_ALARM : MODE_TEST;
          level_next        = 1'b0;
          stop_pending_next = 1'b0;
          beeps_begun_next  = '0;
          next_edge_next    = time_now;
          alarm_begin_next  = (op == OP_START_ALARM) ? time_now : '0;
        end
      end
      OP_STOP: begin
        if (is_alarm) begin
          stop_pending_next = 1'b1;
          next_edge_next    = time_now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      level        <= 1'b0;
      stop_pending <= 1'b0;
      beeps_begun  <= '0;
      time_now     <= '0;
      next_edge    <= '0;
      alarm_begin  <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      level        <= level_next;
      stop_pending <= stop_pending_next;
      beeps_begun  <= beeps_begun_next;
      time_now     <= time_now_next;
      next_edge    <= next_edge_next;
      alarm_begin  <= alarm_begin_next;
    end
  end

  // Result register with a skid register behind it
  logic [7:0] result;
  logic [7:0] skid_data;
  logic       skid_valid;

  assign result = {1'b0, finish, status, (mode_next == MODE_ALARM),
                   (mode_next != MODE_IDLE), level_next};

  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (accept) begin
        m_tdata <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  `BBPS_ASSERT_ALWAYS(a_skid_behind_full, clk, rst, !skid_valid || m_tvalid, "skid register holds a result while the output is empty")
  `BBPS_ASSERT_ALWAYS(a_idle_quiet, clk, rst, (mode != MODE_IDLE) || (!level && !stop_pending), "idle sequencer has buzzer on or stop pending")
  `BBPS_ASSERT_ALWAYS(a_stop_only_alarm, clk, rst, !stop_pending || (mode == MODE_ALARM), "stop pending outside alarm mode")
  `BBPS_ASSERT_NEXT(a_stop_sets_pending, clk, rst, accept && (op == OP_STOP) && (mode == MODE_ALARM), stop_pending, "stop request in alarm did not set stop pending")
  `BBPS_ASSERT_ALWAYS(a_alarm_flags, clk, rst, !m_tvalid || !m_tdata[2] || m_tdata[1], "alarm flag set without pattern flag")

endmodule

// ===== sim/buzzer_result_checker.sv =====
`timescale 1ns / 100ps

module buzzer_result_checker
  import bbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] drive_ok, [7:1] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [0] buzzer_on, [1] pattern_active, [2] alarm_active,
                                 // [4:3] start_status, [6:5] finish_event, [7] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic          buzzer_on;
    logic          pattern_active;
    logic          alarm_active;
    start_status_t start_status;
    finish_event_t finish_event;
  } buzzer_result_t;

  // Register copy.
  logic        present;
  logic [15:0] test_on;
  logic [15:0] test_off;
  logic [15:0] alarm_on;
  logic [15:0] alarm_off;
  logic [15:0] pause_ms;
  logic [31:0] limit_ms;
  logic [7:0]  per_group;

  // Pattern state.
  mode_t       mode;
  logic        level;
  logic        stop_req;
  logic [7:0]  beeps_done;
  logic [31:0] clock_ms;
  logic [31:0] edge_at;
  logic [31:0] alarm_t0;

  buzzer_result_t expected_results[$];
  buzzer_result_t want;
  buzzer_result_t got;

  function automatic logic edge_is_due();
    logic [31:0] lag;
    lag = clock_ms - edge_at;
    return !lag[31];
  endfunction

  function automatic void back_to_idle();
    level = 1'b0;
    stop_req = 1'b0;
    mode = MODE_IDLE;
    beeps_done = 8'd0;
    edge_at = 32'd0;
    alarm_t0 = 32'd0;
  endfunction

  function automatic start_status_t start_pattern(mode_t wanted, logic ok);
    if (!present) return START_UNAVAILABLE;
    if (mode != MODE_IDLE) return START_BUSY;
    // The off write that arms the pattern failed.
    if (!ok) return START_UNAVAILABLE;
    mode = wanted;
    level = 1'b0;
    stop_req = 1'b0;
    beeps_done = 8'd0;
    edge_at = clock_ms;
    alarm_t0 = (wanted == MODE_ALARM) ? clock_ms : 32'd0;
    return START_OK;
  endfunction

  function automatic finish_event_t advance_ms(logic ok);
    logic        in_alarm;
    logic [31:0] elapsed;
    if (mode == MODE_IDLE) return FINISH_NONE;
    in_alarm = (mode == MODE_ALARM);
    elapsed = clock_ms - alarm_t0;
    // Past the alarm limit the stop edge is pulled to now on every tick.
    if (in_alarm && elapsed >= limit_ms) begin
      stop_req = 1'b1;
      edge_at = clock_ms;
    end
    if (stop_req) begin
      if (!edge_is_due()) return FINISH_NONE;
      if (!ok) begin
        edge_at = clock_ms + RETRY_MS;
        return FINISH_NONE;
      end
      back_to_idle();
      return FINISH_STOPPED;
    end
    if (!edge_is_due()) return FINISH_NONE;
    if (level) begin
      if (!ok) begin
        edge_at = clock_ms + RETRY_MS;
        return FINISH_NONE;
      end
      level = 1'b0;
      if (beeps_done >= per_group) begin
        if (!in_alarm) begin
          back_to_idle();
          return FINISH_TEST_DONE;
        end
        beeps_done = 8'd0;
        edge_at = clock_ms + pause_ms;
      end else begin
        edge_at = clock_ms + (in_alarm ? alarm_off : test_off);
      end
      return FINISH_NONE;
    end
    // A failed on write ends the pattern with the buzzer off.
    if (!ok) begin
      back_to_idle();
      return FINISH_ERROR;
    end
    level = 1'b1;
    beeps_done = beeps_done + 8'd1;
    edge_at = clock_ms + (in_alarm ? alarm_on : test_on);
    return FINISH_NONE;
  endfunction

  function automatic buzzer_result_t predict_request(opcode_t op, logic ok);
    buzzer_result_t r;
    r.start_status = START_NONE;
    r.finish_event = FINISH_NONE;
    case (op)
      OP_TICK: begin
        clock_ms = clock_ms + 32'd1;
        r.finish_event = advance_ms(ok);
      end
      OP_START_TEST: begin
        r.start_status = start_pattern(MODE_TEST, ok);
      end
      OP_START_ALARM: begin
        r.start_status = start_pattern(MODE_ALARM, ok);
      end
      default: begin
        if (mode == MODE_ALARM) begin
          stop_req = 1'b1;
          edge_at = clock_ms;
        end
      end
    endcase
    r.buzzer_on = level;
    r.pattern_active = (mode != MODE_IDLE);
    r.alarm_active = (mode == MODE_ALARM);
    return r;
  endfunction

  task automatic compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count = 0;
      present = 1'b0;
      test_on = TEST_ON_RESET;
      test_off = TEST_OFF_RESET;
      alarm_on = ALARM_ON_RESET;
      alarm_off = ALARM_OFF_RESET;
      pause_ms = GROUP_PAUSE_RESET;
      limit_ms = ALARM_LIMIT_RESET;
      per_group = BEEPS_RESET;
      back_to_idle();
      clock_ms = 32'd0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[1], m_tdata[2], start_status_t'(m_tdata[4:3]),
               finish_event_t'(m_tdata[6:5])};
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("buzzer_on", want.buzzer_on, got.buzzer_on);
          compare_field("pattern_active", want.pattern_active, got.pattern_active);
          compare_field("alarm_active", want.alarm_active, got.alarm_active);
          compare_field("start_status", want.start_status, got.start_status);
          compare_field("finish_event", want.finish_event, got.finish_event);
        end
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_DEVICE_PRESENT:  present = cfg_data[0];
          REG_TEST_ON_MS:      test_on = cfg_data[15:0];
          REG_TEST_OFF_MS:     test_off = cfg_data[15:0];
          REG_ALARM_ON_MS:     alarm_on = cfg_data[15:0];
          REG_ALARM_OFF_MS:    alarm_off = cfg_data[15:0];
          REG_GROUP_PAUSE_MS:  pause_ms = cfg_data[15:0];
          REG_ALARM_LIMIT_MS:  limit_ms = cfg_data;
          REG_BEEPS_PER_GROUP: per_group = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_request(opcode_t'(s_tuser), s_tdata[0]));
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== sim/buzzer_beep_pattern_sequencer_test.sv =====
`timescale 1ns / 100ps

module buzzer_beep_pattern_sequencer_test;
  import bbps_pkg::*;

  typedef logic [31:0] reg_set_t [8];

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int fail_count;
  int pending_results;
  int cycles;
  int hold_requests;
  int hold_served;
  int hold_left;
  bit quiet;

  buzzer_beep_pattern_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  buzzer_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("buzzer_beep_pattern_sequencer test failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked.
  initial begin
    m_tready = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (!quiet && (cycles % 400) > 120 && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic offer(opcode_t op, logic ok);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, ok};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender();
    int n;
    n = $urandom_range(1, 14);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_regs(reg_set_t vals);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks with the driver working, so patterns run through to their ends.
  task automatic random_requests(int count);
    int pick;
    opcode_t op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) op = OP_TICK;
      else if (pick < 86) op = OP_START_TEST;
      else if (pick < 94) op = OP_START_ALARM;
      else op = OP_STOP;
      if (!quiet && (i % 100) >= 30 && $urandom_range(0, 5) == 0) pause_sender();
      offer(op, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tuser = OP_TICK;
    cfg_we = 1'b0;
    cfg_index = REG_DEVICE_PRESENT;
    cfg_data = 32'd0;
    hold_requests = 0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the driver is absent, so every start is refused.
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b0);
    offer(OP_START_TEST, 1'b1);
    offer(OP_START_ALARM, 1'b0);
    offer(OP_STOP, 1'b1);

    program_regs('{32'd1, 32'd2, 32'd1, 32'd1, 32'd1, 32'd3, 32'd40, 32'd2});
    offer(OP_START_TEST, 1'b0);   // arming write fails
    offer(OP_START_TEST, 1'b1);
    offer(OP_START_ALARM, 1'b1);  // busy
    offer(OP_STOP, 1'b1);         // ignored outside alarm
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b0);         // on write fails and ends the test
    offer(OP_START_TEST, 1'b1);
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b0);         // off write fails and is retried later
    offer(OP_START_ALARM, 1'b1);
    offer(OP_TICK, 1'b1);
    offer(OP_STOP, 1'b1);
    offer(OP_TICK, 1'b0);
    offer(OP_TICK, 1'b1);
    offer(OP_START_ALARM, 1'b1);
    offer(OP_TICK, 1'b1);
    offer(OP_TICK, 1'b1);
    random_requests(200);

    // All times zero and an alarm limit of zero: the stop is forced every tick.
    program_regs('{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
    random_requests(200);

    program_regs('{32'd0, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd30, 32'd2});
    random_requests(60);

    program_regs('{32'd1, 32'd3, 32'd5, 32'd2, 32'd4, 32'd8, 32'd150, 32'd4});
    hold_requests++;
    random_requests(250);

    // A beep count of zero gives single-beep tests and groups.
    program_regs('{32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd2, 32'd60, 32'd0});
    random_requests(200);

    program_regs('{32'd1, 32'($urandom_range(0, 2)), 32'($urandom_range(0, 2)),
                   32'($urandom_range(0, 2)), 32'($urandom_range(0, 2)),
                   32'($urandom_range(0, 20)), 32'($urandom_range(100, 500)), 32'd255});
    random_requests(200);

    // Largest values last, since a test started here never finishes.
    program_regs('{32'd1, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                   32'hFFFF_FFFF, 32'd255});
    quiet = 1'b1;
    random_requests(200);

    drain();
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("buzzer_beep_pattern_sequencer test passed");
    end else begin
      $display("buzzer_beep_pattern_sequencer test failed");
    end
    $finish;
  end

endmodule
